// ----- rtl/owm_pkg.sv -----
package owm_pkg;

  localparam int TICK_W        = 10;
  localparam int BYTE_W        = 8;
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int CFG_ADDR_W    = 5;
  localparam int CFG_DATA_W    = 32;
  localparam int CMD_W         = 2;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_REC     = 3'd2;
  localparam logic [2:0] REG_WRITE_ONE_LOW = 3'd3;
  localparam logic [2:0] REG_SLOT          = 3'd4;
  localparam logic [2:0] REG_READ_LOW      = 3'd5;

  localparam logic [TICK_W-1:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [TICK_W-1:0] PRESENCE_WAIT_DEF = 10'd80;
  localparam logic [TICK_W-1:0] RESET_REC_DEF     = 10'd400;
  localparam logic [TICK_W-1:0] WRITE_ONE_LOW_DEF = 10'd1;
  localparam logic [TICK_W-1:0] SLOT_DEF          = 10'd60;
  localparam logic [TICK_W-1:0] READ_LOW_DEF      = 10'd2;

  typedef struct packed {
    logic [TICK_W-1:0] reset_low_ticks;
    logic [TICK_W-1:0] presence_wait_ticks;
    logic [TICK_W-1:0] reset_recovery_ticks;
    logic [TICK_W-1:0] write_one_low_ticks;
    logic [TICK_W-1:0] slot_ticks;
    logic [TICK_W-1:0] read_low_ticks;
  } owm_cfg_t;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    at_least_one = (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

// ----- rtl/owm_if.sv -----
interface owm_in_if;
  logic                         valid;
  logic                         ready;
  logic [owm_pkg::CMD_W-1:0]    cmd;
  logic [owm_pkg::BYTE_W-1:0]   write_byte;
  logic                         line_level;

  modport source (output valid, cmd, write_byte, line_level, input ready);
  modport sink (input valid, cmd, write_byte, line_level, output ready);
endinterface

interface owm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         drive_low;
  logic                         busy_res;
  logic                         done_res;
  logic                         presence;
  logic [owm_pkg::BYTE_W-1:0]   read_data;

  modport source (output valid, drive_low, busy_res, done_res, presence, read_data,
                  input ready);
  modport sink (input valid, drive_low, busy_res, done_res, presence, read_data,
                output ready);
endinterface

// ----- rtl/owm_cfg_regs.sv -----
module owm_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [owm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [owm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [owm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output owm_pkg::owm_cfg_t                 cfg
);

  owm_pkg::owm_cfg_t cfg_r;
  logic [2:0] reg_idx;
  logic [owm_pkg::TICK_W-1:0] wval;
  logic [owm_pkg::TICK_W-1:0] rval;
  logic wr_en;

  assign reg_idx = paddr[owm_pkg::CFG_ADDR_W-1:2];
  assign wval    = pwdata[owm_pkg::TICK_W-1:0];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks      <= owm_pkg::RESET_LOW_DEF;
      cfg_r.presence_wait_ticks  <= owm_pkg::PRESENCE_WAIT_DEF;
      cfg_r.reset_recovery_ticks <= owm_pkg::RESET_REC_DEF;
      cfg_r.write_one_low_ticks  <= owm_pkg::WRITE_ONE_LOW_DEF;
      cfg_r.slot_ticks           <= owm_pkg::SLOT_DEF;
      cfg_r.read_low_ticks       <= owm_pkg::READ_LOW_DEF;
    end else if (wr_en) begin
      case (reg_idx)
        owm_pkg::REG_RESET_LOW:     cfg_r.reset_low_ticks      <= wval;
        owm_pkg::REG_PRESENCE_WAIT: cfg_r.presence_wait_ticks  <= wval;
        owm_pkg::REG_RESET_REC:     cfg_r.reset_recovery_ticks <= wval;
        owm_pkg::REG_WRITE_ONE_LOW: cfg_r.write_one_low_ticks  <= wval;
        owm_pkg::REG_SLOT:          cfg_r.slot_ticks           <= wval;
        owm_pkg::REG_READ_LOW:      cfg_r.read_low_ticks       <= wval;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      owm_pkg::REG_RESET_LOW:     rval = cfg_r.reset_low_ticks;
      owm_pkg::REG_PRESENCE_WAIT: rval = cfg_r.presence_wait_ticks;
      owm_pkg::REG_RESET_REC:     rval = cfg_r.reset_recovery_ticks;
      owm_pkg::REG_WRITE_ONE_LOW: rval = cfg_r.write_one_low_ticks;
      owm_pkg::REG_SLOT:          rval = cfg_r.slot_ticks;
      owm_pkg::REG_READ_LOW:      rval = cfg_r.read_low_ticks;
      default:                    rval = '0;
    endcase
  end

  assign prdata = owm_pkg::CFG_DATA_W'(rval);
  assign cfg    = cfg_r;

endmodule

// ----- rtl/one_wire_bus_master_core.sv -----
// 1-Wire bus master driven by one-microsecond tick transfers: every input transfer is one tick
// and yields exactly one result transfer describing what the master does in that tick. The core
// accepts one tick per clock cycle while the result channel is not stalled; a tick passes through
// an input register and the bus sequencer logic into a result register, where its result is
// offered, and the sequencer state advances once per tick as that tick moves into the result
// register.
module one_wire_bus_master_core (
  input  logic                              clk,
  input  logic                              rst_n,
  owm_in_if.sink                            in_ch,
  owm_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [owm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [owm_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [owm_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RST_LOW  = 4'd1;
  localparam logic [3:0] PH_RST_WAIT = 4'd2;
  localparam logic [3:0] PH_RST_REC  = 4'd3;
  localparam logic [3:0] PH_W_LOW    = 4'd4;
  localparam logic [3:0] PH_W_REL    = 4'd5;
  localparam logic [3:0] PH_R_LOW    = 4'd6;
  localparam logic [3:0] PH_R_SAMP   = 4'd7;
  localparam logic [3:0] PH_R_REL    = 4'd8;

  localparam logic [owm_pkg::BIT_IDX_W-1:0] LAST_BIT =
    owm_pkg::BIT_IDX_W'(owm_pkg::BITS_PER_BYTE - 1);

  owm_pkg::owm_cfg_t cfg;

  owm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  logic                               s1_valid_r;
  logic [owm_pkg::CMD_W-1:0]          s1_cmd_r;
  logic [owm_pkg::BYTE_W-1:0]         s1_wb_r;
  logic                               s1_line_r;

  logic                               out_valid_r;
  logic                               drive_r;
  logic                               busy_r;
  logic                               done_r;

  logic [3:0]                         phase_r, phase_nxt;
  logic [owm_pkg::TICK_W-1:0]         tick_count_r, tick_count_nxt;
  logic [owm_pkg::BIT_IDX_W-1:0]      bit_index_r, bit_index_nxt;
  logic [owm_pkg::BYTE_W-1:0]         shift_byte_r, shift_byte_nxt;
  logic                               presence_r, presence_nxt;
  logic [owm_pkg::BYTE_W-1:0]         last_read_r, last_read_nxt;

  logic                               drive_nxt;
  logic                               busy_nxt;
  logic                               done_nxt;
  logic [owm_pkg::TICK_W-1:0]         tc_dec;
  logic                               advance;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_cmd_r  <= in_ch.cmd;
      s1_wb_r   <= in_ch.write_byte;
      s1_line_r <= in_ch.line_level;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    bit_index_nxt  = bit_index_r;
    shift_byte_nxt = shift_byte_r;
    presence_nxt   = presence_r;
    last_read_nxt  = last_read_r;
    drive_nxt      = 1'b0;
    done_nxt       = 1'b0;

    if (phase_r == PH_IDLE && s1_cmd_r != owm_pkg::CMD_TICK) begin
      bit_index_nxt = '0;
      case (s1_cmd_r)
        owm_pkg::CMD_RESET: begin
          phase_nxt      = PH_RST_LOW;
          tick_count_nxt = owm_pkg::at_least_one(cfg.reset_low_ticks);
        end
        owm_pkg::CMD_WRITE: begin
          shift_byte_nxt = s1_wb_r;
          phase_nxt      = PH_W_LOW;
          tick_count_nxt = s1_wb_r[0] ? owm_pkg::at_least_one(cfg.write_one_low_ticks)
                                      : owm_pkg::at_least_one(cfg.slot_ticks);
        end
        default: begin
          shift_byte_nxt = '0;
          phase_nxt      = PH_R_LOW;
          tick_count_nxt = owm_pkg::at_least_one(cfg.read_low_ticks);
        end
      endcase
    end

    busy_nxt = (phase_nxt != PH_IDLE);
    tc_dec   = tick_count_nxt - owm_pkg::TICK_W'(1);

    case (phase_nxt)
      PH_RST_LOW: begin
        drive_nxt      = 1'b1;
        tick_count_nxt = tc_dec;
        if (tc_dec == '0) begin
          phase_nxt      = PH_RST_WAIT;
          tick_count_nxt = owm_pkg::at_least_one(cfg.presence_wait_ticks);
        end
      end
      PH_RST_WAIT: begin
        tick_count_nxt = tc_dec;
        if (tc_dec == '0) begin
          presence_nxt = !s1_line_r;
          if (cfg.reset_recovery_ticks == '0) begin
            phase_nxt      = PH_IDLE;
            tick_count_nxt = '0;
            done_nxt       = 1'b1;
          end else begin
            phase_nxt      = PH_RST_REC;
            tick_count_nxt = cfg.reset_recovery_ticks;
          end
        end
      end
      PH_RST_REC: begin
        tick_count_nxt = tc_dec;
        if (tc_dec == '0) begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
      end
      PH_W_LOW: begin
        drive_nxt      = 1'b1;
        tick_count_nxt = tc_dec;
        if (tc_dec == '0) begin
          phase_nxt      = PH_W_REL;
          tick_count_nxt = shift_byte_nxt[0] ? owm_pkg::at_least_one(cfg.slot_ticks)
                                             : owm_pkg::TICK_W'(1);
        end
      end
      PH_W_REL: begin
        tick_count_nxt = tc_dec;
        if (tc_dec == '0) begin
          if (bit_index_nxt == LAST_BIT) begin
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end else begin
            shift_byte_nxt = shift_byte_nxt >> 1;
            bit_index_nxt  = bit_index_nxt + owm_pkg::BIT_IDX_W'(1);
            phase_nxt      = PH_W_LOW;
            tick_count_nxt = shift_byte_nxt[0] ? owm_pkg::at_least_one(cfg.write_one_low_ticks)
                                               : owm_pkg::at_least_one(cfg.slot_ticks);
          end
        end
      end
      PH_R_LOW: begin
        drive_nxt      = 1'b1;
        tick_count_nxt = tc_dec;
        if (tc_dec == '0) begin
          phase_nxt      = PH_R_SAMP;
          tick_count_nxt = owm_pkg::TICK_W'(1);
        end
      end
      PH_R_SAMP: begin
        shift_byte_nxt = {s1_line_r, shift_byte_nxt[owm_pkg::BYTE_W-1:1]};
        phase_nxt      = PH_R_REL;
        tick_count_nxt = owm_pkg::at_least_one(cfg.slot_ticks);
      end
      PH_R_REL: begin
        tick_count_nxt = tc_dec;
        if (tc_dec == '0) begin
          if (bit_index_nxt == LAST_BIT) begin
            last_read_nxt = shift_byte_nxt;
            phase_nxt     = PH_IDLE;
            done_nxt      = 1'b1;
          end else begin
            bit_index_nxt  = bit_index_nxt + owm_pkg::BIT_IDX_W'(1);
            phase_nxt      = PH_R_LOW;
            tick_count_nxt = owm_pkg::at_least_one(cfg.read_low_ticks);
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= '0;
      bit_index_r  <= '0;
      shift_byte_r <= '0;
      presence_r   <= 1'b0;
      last_read_r  <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_byte_r <= shift_byte_nxt;
      presence_r   <= presence_nxt;
      last_read_r  <= last_read_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_r <= drive_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive_low = drive_r;
  assign out_ch.busy_res  = busy_r;
  assign out_ch.done_res  = done_r;
  assign out_ch.presence  = presence_r;
  assign out_ch.read_data = last_read_r;

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tick_count_r == '0)
    else $error("tick count not cleared while idle");

  a_busy_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> tick_count_r != '0)
    else $error("tick count reached zero during an operation");

  a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (done_r || drive_r) |-> busy_r)
    else $error("done or drive reported outside an operation");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && done_nxt |=> phase_r == PH_IDLE)
    else $error("sequencer not idle after a finished operation");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(phase_r) && $stable(tick_count_r))
    else $error("sequencer state moved without a tick transfer");

endmodule
